>>> design/wbps_pkg.sv
package wbps_pkg;

    // Largest pattern the matcher can hold, in bytes (1 to 16).
    localparam int MAX_PATTERN_BYTES = 16;

    // Derived sizes.
    localparam int LEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;

    // Fixed field widths.
    localparam int POS_W   = 48;
    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PLEN_W  = 5;
    localparam int MASK_W  = 16;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_IMAGE_BASE   = 3'd4,
        REG_RESULT_LIMIT = 3'd5
    } cfg_index_t;

    // Current configuration as seen by the matcher.
    typedef struct packed {
        logic [2*CFG_W-1:0]  pattern;
        logic [MASK_W-1:0]   care_mask;
        logic [PLEN_W-1:0]   pattern_length;
        logic [ADDR_W-1:0]   image_base;
        logic [COUNT_W-1:0]  result_limit;
    } cfg_t;

    // Outcome of scanning one byte.
    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   match_address;
        logic [COUNT_W-1:0]  match_number;
        logic                limit_hit;
    } match_t;

endpackage

>>> design/wbps_cfg.sv
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Register file: one write per cycle, unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern        <= '0;
            cfg_reg.care_mask      <= '0;
            cfg_reg.pattern_length <= '0;
            cfg_reg.image_base     <= '0;
            cfg_reg.result_limit   <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  cfg_reg.pattern[CFG_W-1:0]       <= cfg_wdata;
                REG_PATTERN_HIGH: cfg_reg.pattern[2*CFG_W-1:CFG_W] <= cfg_wdata;
                REG_CARE_MASK:    cfg_reg.care_mask      <= cfg_wdata[MASK_W-1:0];
                REG_PATTERN_LEN:  cfg_reg.pattern_length <= cfg_wdata[PLEN_W-1:0];
                REG_IMAGE_BASE:   cfg_reg.image_base     <= cfg_wdata;
                REG_RESULT_LIMIT: cfg_reg.result_limit   <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/wbps_match.sv
module wbps_match
    import wbps_pkg::*;
(
    input  cfg_t                cfg,
    input  logic [7:0]          cur_byte,
    input  logic [7:0]          window [WIN_DEPTH],
    input  logic [POS_W-1:0]    position,
    input  logic [COUNT_W-1:0]  matches_found,
    output match_t              result
);

    logic [7:0]         recent [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   back;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] number;
    logic [POS_W-1:0]   start;
    logic               all_equal;
    logic               enabled;

    // Most recent bytes: entry 0 is the current byte, entry i is i bytes back.
    always_comb begin
        recent[0] = cur_byte;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
            recent[i] = window[i-1];
        end
    end

    // Clamp the length and map a zero limit to one.
    always_comb begin
        if (cfg.pattern_length > PLEN_W'(MAX_PATTERN_BYTES)) begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = LEN_W'(cfg.pattern_length);
        end
        len_m1 = len_eff - LEN_W'(1);
        limit  = (cfg.result_limit == '0) ? COUNT_W'(1) : cfg.result_limit;
    end

    // Masked compare of every pattern byte against its place in the window.
    always_comb begin
        all_equal = 1'b1;
        back      = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            back = len_m1 - LEN_W'(k);
            if ((LEN_W'(k) < len_eff) && cfg.care_mask[k]) begin
                if (recent[back[IDX_W-1:0]] != cfg.pattern[8*k +: 8]) begin
                    all_equal = 1'b0;
                end
            end
        end
    end

    // Gate on length, bytes seen and limit, then form the result fields.
    always_comb begin
        enabled = (len_eff != '0) && (position >= POS_W'(len_m1)) && (matches_found < limit);
        start   = position - POS_W'(len_m1);
        number  = matches_found + COUNT_W'(1);
        result.hit           = enabled && all_equal;
        result.match_address = cfg.image_base + ADDR_W'(start);
        result.match_number  = number;
        result.limit_hit     = (number >= limit);
    end

endmodule

>>> design/wildcard_byte_pattern_scanner.sv
// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+----------------------------------------------
// input     | in        | s_valid / s_ready | s_data_byte, s_image_end
// result    | out       | m_valid / m_ready | m_match_address, m_match_number, m_limit_hit
// config    | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// One byte per cycle sustained while the result channel is not stalled: a byte is registered,
// scanned by the 16-byte masked compare and the start-address adder, and a match is registered.
// Reset (aresetn low, synchronous) sets the result limit to one, clears the rest of the
// configuration, both valid stages and the counters.
// A stalled result holds the scan stage; the input register still takes one more byte if empty.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_image_end,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_match_address,
    output logic [COUNT_W-1:0]   m_match_number,
    output logic                 m_limit_hit
);

    cfg_t   cfg;
    match_t res;

    logic               in_valid_reg;
    logic [7:0]         data_reg;
    logic               end_reg;

    logic [7:0]         window_reg [WIN_DEPTH];
    logic [POS_W-1:0]   pos_reg;
    logic [COUNT_W-1:0] found_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [COUNT_W-1:0] number_reg;
    logic               limit_hit_reg;

    logic               advance;

    wbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wbps_match u_match (
        .cfg           (cfg),
        .cur_byte      (data_reg),
        .window        (window_reg),
        .position      (pos_reg),
        .matches_found (found_reg),
        .result        (res)
    );

    // The scan stage moves when it holds a byte and the result slot is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
            end_reg  <= s_image_end;
        end
    end

    // Image state: the window needs no reset, since only bytes of the current
    // image are ever compared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            found_reg <= '0;
        end else if (advance) begin
            if (end_reg) begin
                pos_reg   <= '0;
                found_reg <= '0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                if (res.hit) begin
                    found_reg <= res.match_number;
                end
            end
        end
        if (advance) begin
            window_reg[0] <= data_reg;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.hit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && res.hit) begin
            address_reg   <= res.match_address;
            number_reg    <= res.match_number;
            limit_hit_reg <= res.limit_hit;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_match_address = address_reg;
    assign m_match_number  = number_reg;
    assign m_limit_hit     = limit_hit_reg;

    // A reported match always carries a nonzero ordinal.
    a_number_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (number_reg != '0))
        else $error("match reported with ordinal zero");

    // The last byte of an image clears position and match count.
    a_image_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && end_reg) |=> (pos_reg == '0) && (found_reg == '0))
        else $error("image state not cleared after image end");

    // The match count only moves when a match is reported or an image ends.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && (res.hit || end_reg)) |=> $stable(found_reg))
        else $error("match count changed without a match");

    // A reported match is written into the count in the same transfer.
    a_count_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.hit && !end_reg) |=> (found_reg == number_reg))
        else $error("match count disagrees with reported ordinal");

endmodule
